[design/tlcb_pkg.sv]
// ----------------------------------------------------------------------------
// tlcb_pkg: shared types and constants of the line capture buffer
// Operation words passed from the front end to the back end, result words,
// result kinds, register indexes and the special characters.
// ----------------------------------------------------------------------------
package tlcb_pkg;

  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_DOT    = 8'h2e;

  localparam int MATCH_W = 4;

  // The result fields are sized for this buffer, so it does not vary.
  localparam int BUF_BYTES = 512;

  typedef enum logic [1:0] {
    CFG_MARKER_BYTES  = 2'd0,
    CFG_MARKER_LENGTH = 2'd1,
    CFG_START_SIZE    = 2'd2,
    CFG_TRUNCATE_MODE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DOT   = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_END   = 2'd1,
    OP_ACK   = 2'd2
  } op_kind_e;

  // One classified input word. A store replays the first replay marker
  // characters, stores ch and, for a newline, adds a request or a prompt.
  typedef struct packed {
    op_kind_e             kind;
    logic [7:0]           ch;
    logic [MATCH_W-1:0]   replay;
    logic                 newline;
    logic                 end_flag;
  } op_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic [8:0]  buf_index;
    logic [31:0] write_offset;
    logic [8:0]  write_length;
    logic        write_half;
    logic        truncate_first;
    logic        last;
  } res_t;

endpackage

[design/tlcb_fifo.sv]
// ----------------------------------------------------------------------------
// tlcb_fifo: small register queue
// Generic first-in first-out queue in flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
module tlcb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push_en, pop_en;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push_en = push_i && !full_o;
  assign pop_en  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_en) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_en) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_en && !pop_en) begin
      count_d = count_q + CW'(1);
    end else if (pop_en && !push_en) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[design/tlcb_front.sv]
// ----------------------------------------------------------------------------
// tlcb_front: character classifier
// Tracks the end marker match at each line start and turns every accepted
// input word into one operation word for the back end, or into none.
// ----------------------------------------------------------------------------
module tlcb_front #(
  parameter int MARKER_MAX = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              command_i,
  input  logic [7:0]        char_in_i,
  input  logic [63:0]       marker_bytes_i,
  input  logic [3:0]        marker_length_i,
  output logic              op_valid_o,
  output tlcb_pkg::op_t     op_o
);

  import tlcb_pkg::*;

  localparam logic [MATCH_W-1:0] MaxCnt = MATCH_W'(MARKER_MAX);

  logic [MATCH_W-1:0] matched_q, matched_d;
  logic               mismatch_q, mismatch_d;
  logic               end_q, end_d;
  logic [MATCH_W-1:0] eff_len;
  logic [MATCH_W-1:0] matched_inc;
  logic [7:0]         mchar;

  assign mchar       = marker_bytes_i[{matched_q[2:0], 3'b000} +: 8];
  assign matched_inc = matched_q + MATCH_W'(1);

  always_comb begin
    eff_len = marker_length_i;
    if (eff_len == '0) begin
      eff_len = MATCH_W'(1);
    end
    if (eff_len > MaxCnt) begin
      eff_len = MaxCnt;
    end
  end

  always_comb begin
    matched_d       = matched_q;
    mismatch_d      = mismatch_q;
    end_d           = end_q;
    op_valid_o      = 1'b0;
    op_o.kind       = OP_STORE;
    op_o.ch         = char_in_i;
    op_o.replay     = '0;
    op_o.newline    = 1'b0;
    op_o.end_flag   = end_q;
    if (accept_i) begin
      if (command_i) begin
        op_valid_o = 1'b1;
        op_o.kind  = OP_ACK;
      end else if (end_q || char_in_i == CHAR_CR) begin
        op_valid_o = 1'b0;
      end else if (char_in_i == CHAR_LF) begin
        op_valid_o   = 1'b1;
        op_o.replay  = mismatch_q ? '0 : matched_q;
        op_o.newline = 1'b1;
        matched_d    = '0;
        mismatch_d   = 1'b0;
      end else if (mismatch_q) begin
        op_valid_o = 1'b1;
      end else if (matched_q < MaxCnt && char_in_i == mchar) begin
        matched_d = matched_inc;
        if (matched_inc >= eff_len) begin
          end_d      = 1'b1;
          op_valid_o = 1'b1;
          op_o.kind  = OP_END;
        end
      end else begin
        // First mismatch: the held prefix goes into the buffer ahead of it.
        mismatch_d  = 1'b1;
        op_valid_o  = 1'b1;
        op_o.replay = matched_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q  <= '0;
      mismatch_q <= 1'b0;
      end_q      <= 1'b0;
    end else begin
      matched_q  <= matched_d;
      mismatch_q <= mismatch_d;
      end_q      <= end_d;
    end
  end

endmodule

[design/tlcb_back.sv]
// ----------------------------------------------------------------------------
// tlcb_back: buffer sequencer
// Carries out operation words one result per cycle unless the result queue
// is full: replays held marker bytes, stores characters, issues chunk write
// requests and prompts, and keeps the ping-pong buffer flags and file offset.
// ----------------------------------------------------------------------------
module tlcb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  tlcb_pkg::op_t     op_i,
  output logic              op_pop_o,
  input  logic [63:0]       marker_bytes_i,
  input  logic              load_i,
  input  logic [31:0]       start_size_i,
  input  logic              truncate_mode_i,
  output logic              res_valid_o,
  output tlcb_pkg::res_t    res_o,
  input  logic              res_full_i
);

  import tlcb_pkg::*;

  localparam int FW    = $clog2(BUF_BYTES);
  localparam int CHUNK = BUF_BYTES / 2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REPLAY = 6'b000010,
    ST_CHAR   = 6'b000100,
    ST_TAIL   = 6'b001000,
    ST_END    = 6'b010000,
    ST_ACK    = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  op_t           op_q, op_d;
  logic [2:0]    idx_q, idx_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          lower_q, lower_d;
  logic          upper_q, upper_d;
  logic [31:0]   base_q, base_d;
  logic          pend_q, pend_d;
  logic          wr_out_q, wr_out_d;

  logic          store_en;
  logic [7:0]    store_ch;
  logic          req_en;
  logic          req_half;
  logic [8:0]    req_len;
  logic [FW:0]   fill_inc;
  logic [FW-2:0] part;
  logic [7:0]    mchar;

  assign mchar    = marker_bytes_i[{idx_q, 3'b000} +: 8];
  assign fill_inc = {1'b0, fill_q} + (FW+1)'(1);
  assign part     = fill_q[FW-2:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    lower_d     = lower_q;
    upper_d     = upper_q;
    base_d      = base_q;
    pend_d      = pend_q;
    wr_out_d    = wr_out_q;
    op_pop_o    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    store_en    = 1'b0;
    store_ch    = op_q.ch;
    req_en      = 1'b0;
    req_half    = 1'b0;
    req_len     = 9'(CHUNK);

    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          idx_d    = '0;
          case (op_i.kind)
            OP_STORE: state_d = (op_i.replay != '0) ? ST_REPLAY : ST_CHAR;
            OP_END:   state_d = ST_END;
            OP_ACK:   state_d = wr_out_q ? ST_ACK : ST_IDLE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_REPLAY: begin
        if (!res_full_i) begin
          store_en = 1'b1;
          store_ch = mchar;
          idx_d    = idx_q + 3'd1;
          if ({1'b0, idx_q} + MATCH_W'(1) == op_q.replay) begin
            state_d = ST_CHAR;
          end
        end
      end
      ST_CHAR: begin
        if (!res_full_i) begin
          store_en   = 1'b1;
          res_o.last = !op_q.newline;
          state_d    = op_q.newline ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (!res_full_i) begin
          if (lower_q) begin
            req_en = 1'b1;
          end else if (upper_q) begin
            req_en   = 1'b1;
            req_half = 1'b1;
          end else begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_DOT;
            res_o.byte_value = CHAR_DOT;
          end
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_END: begin
        if (!res_full_i) begin
          // A partial chunk is flushed; an empty one gets the end prompt.
          if (part != '0) begin
            req_en   = 1'b1;
            req_half = fill_q[FW-1];
            req_len  = 9'(part);
          end else begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_END;
            res_o.byte_value = CHAR_DOLLAR;
          end
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (!res_full_i) begin
          if (lower_q) begin
            lower_d = 1'b0;
          end else if (upper_q) begin
            upper_d = 1'b0;
            base_d  = base_q + 32'(BUF_BYTES);
          end
          wr_out_d         = 1'b0;
          res_valid_o      = 1'b1;
          res_o.kind       = op_q.end_flag ? KIND_END : KIND_DOT;
          res_o.byte_value = op_q.end_flag ? CHAR_DOLLAR : CHAR_DOT;
          res_o.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (store_en) begin
      res_valid_o      = 1'b1;
      res_o.kind       = KIND_DATA;
      res_o.byte_value = store_ch;
      res_o.buf_index  = 9'(fill_q);
      if (fill_inc == (FW+1)'(CHUNK)) begin
        lower_d = 1'b1;
        fill_d  = fill_inc[FW-1:0];
      end else if (fill_inc >= (FW+1)'(BUF_BYTES)) begin
        upper_d = 1'b1;
        fill_d  = '0;
      end else begin
        fill_d = fill_inc[FW-1:0];
      end
    end

    if (req_en) begin
      res_valid_o          = 1'b1;
      res_o.kind           = KIND_WRITE;
      res_o.write_offset   = base_q + (req_half ? 32'(CHUNK) : 32'd0);
      res_o.write_length   = req_len;
      res_o.write_half     = req_half;
      res_o.truncate_first = pend_q;
      pend_d               = 1'b0;
      wr_out_d             = 1'b1;
    end

    // A new job reloads the fill position, the file base and the truncate flag.
    if (load_i) begin
      if (truncate_mode_i) begin
        fill_d = '0;
        base_d = '0;
      end else begin
        fill_d = start_size_i[FW-1:0];
        base_d = start_size_i & ~32'(BUF_BYTES - 1);
      end
      pend_d = truncate_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      fill_q   <= '0;
      lower_q  <= 1'b0;
      upper_q  <= 1'b0;
      base_q   <= '0;
      pend_q   <= 1'b0;
      wr_out_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      fill_q   <= fill_d;
      lower_q  <= lower_d;
      upper_q  <= upper_d;
      base_q   <= base_d;
      pend_q   <= pend_d;
      wr_out_q <= wr_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REPLAY |-> ({1'b0, idx_q} < op_q.replay))
    else $error("replay index ran past the held byte count");

  a_write_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_WRITE |-> res_o.last)
    else $error("write request was not the final word of its operation");

  a_write_sets_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_WRITE |=> wr_out_q && !pend_q)
    else $error("write request did not mark a write outstanding");

  a_ack_only_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACK |-> wr_out_q)
    else $error("acknowledge handled with no write outstanding");

endmodule

[design/terminated_line_capture_buffer_unit.sv]
// ----------------------------------------------------------------------------
// terminated_line_capture_buffer_unit: line capture with end marker
// Captures serial text lines into a ping-pong buffer and requests chunk
// writes until an end marker line is seen.
// ----------------------------------------------------------------------------
// An input word's operation, if it has one, goes into a two-entry operation
// queue in the cycle it is pushed, so push is stalled only when that queue is
// full. The back-end sequencer then takes the operation and produces its
// result words, stalling while the result queue is full: none for a dropped
// acknowledge, one for a plain character, prompt or end operation, and for a
// newline up to seven replayed marker bytes, the character and a request or
// a prompt. Results pass through a two-entry result queue, so the sequencer
// keeps going while earlier words wait to be popped. The buffer holds 512
// bytes in two halves. Configuration writes are always ready; a write of the
// start size or the truncate mode reloads the fill position via load_q.
// ----------------------------------------------------------------------------
module terminated_line_capture_buffer_unit #(
  parameter int MARKER_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [7:0]  char_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [8:0]  buf_index_o,
  output logic [31:0] write_offset_o,
  output logic [8:0]  write_length_o,
  output logic        write_half_o,
  output logic        truncate_first_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  import tlcb_pkg::*;

  logic [63:0] marker_q;
  logic [3:0]  length_q;
  logic [31:0] start_q;
  logic        trunc_q;
  logic        load_q, load_d;

  logic        in_accept;
  logic        cfg_write;
  logic        front_valid;
  op_t         front_op;
  logic        op_empty;
  logic        op_pop;
  op_t         op_head;
  logic        res_valid;
  logic        res_full;
  res_t        res_in;
  res_t        res_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_accept   = push && !full;

  always_comb begin
    load_d = 1'b0;
    if (cfg_write) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_START_SIZE:    load_d = 1'b1;
        CFG_TRUNCATE_MODE: load_d = 1'b1;
        default:           load_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
      length_q <= 4'd1;
      start_q  <= '0;
      trunc_q  <= 1'b0;
      load_q   <= 1'b0;
    end else begin
      load_q <= load_d;
      if (cfg_write) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_MARKER_BYTES:  marker_q <= cfg_data_i;
          CFG_MARKER_LENGTH: length_q <= cfg_data_i[3:0];
          CFG_START_SIZE:    start_q  <= cfg_data_i[31:0];
          CFG_TRUNCATE_MODE: trunc_q  <= cfg_data_i[0];
          default:           marker_q <= marker_q;
        endcase
      end
    end
  end

  tlcb_front #(
    .MARKER_MAX (MARKER_MAX)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .command_i       (command_i),
    .char_in_i       (char_in_i),
    .marker_bytes_i  (marker_q),
    .marker_length_i (length_q),
    .op_valid_o      (front_valid),
    .op_o            (front_op)
  );

  tlcb_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (2)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_op),
    .full_o  (full),
    .pop_i   (op_pop),
    .data_o  (op_head),
    .empty_o (op_empty)
  );

  tlcb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (!op_empty),
    .op_i            (op_head),
    .op_pop_o        (op_pop),
    .marker_bytes_i  (marker_q),
    .load_i          (load_q),
    .start_size_i    (start_q),
    .truncate_mode_i (trunc_q),
    .res_valid_o     (res_valid),
    .res_o           (res_in),
    .res_full_i      (res_full)
  );

  tlcb_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign kind_o           = res_out.kind;
  assign byte_value_o     = res_out.byte_value;
  assign buf_index_o      = res_out.buf_index;
  assign write_offset_o   = res_out.write_offset;
  assign write_length_o   = res_out.write_length;
  assign write_half_o     = res_out.write_half;
  assign truncate_first_o = res_out.truncate_first;
  assign last_o           = res_out.last;

endmodule
